FILE: rtl/core/assert_macros.svh
// assertion macros shared by the queue and back end rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define SHCM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// condition that must never hold outside reset
`define SHCM_NEVER(lbl, clk, rst_n, cond) \
  `SHCM_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define SHCM_ASSERT(lbl, clk, rst_n, prop)
`define SHCM_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/core/shcm_pkg.sv
// shared types, constants and helpers of the sparse hermitian multiply core
package shcm_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;
  localparam int QUEUE_DEPTH  = 4;

  // configuration register indexes
  localparam logic [2:0] REG_ALPHA_RE = 3'd0;
  localparam logic [2:0] REG_ALPHA_IM = 3'd1;
  localparam logic [2:0] REG_BETA_RE  = 3'd2;
  localparam logic [2:0] REG_BETA_IM  = 3'd3;
  localparam logic [2:0] REG_NUM_ROWS = 3'd4;
  localparam logic [2:0] REG_NUM_COLS = 3'd5;

  // input mode codes
  localparam logic [1:0] MODE_LOAD_X = 2'd0;
  localparam logic [1:0] MODE_LOAD_Y = 2'd1;
  localparam logic [1:0] MODE_NZ     = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  // classified operations handed from front to back
  typedef enum logic [2:0] {
    OP_LDX = 3'd0,
    OP_LDY = 3'd1,
    OP_NZ  = 3'd2,
    OP_RD  = 3'd3,
    OP_RDZ = 3'd4
  } op_t;

  // kinds of micro op in the multiply pipeline
  typedef enum logic [2:0] {
    K_VAL  = 3'd0,
    K_VALC = 3'd1,
    K_MAC  = 3'd2,
    K_BV   = 3'd3,
    K_AX   = 3'd4,
    K_RD   = 3'd5
  } kind_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cplx_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] row;
    logic [5:0] col;
    cplx_t      v;
  } entry_t;

  typedef struct packed {
    cplx_t alpha;
    cplx_t beta;
  } cfg_t;

  // saturate a widened sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -49'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/shcm_ram.sv
// generic simple dual port ram with registered read
module shcm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/shcm_queue.sv
// short fifo between the classifying front and the executing back
`include "assert_macros.svh"
module shcm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = slot_r[rd_ptr_r];

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `SHCM_NEVER(a_count_range, clk, rst_n, count_r > CW'(DEPTH))
  `SHCM_NEVER(a_pop_empty, clk, rst_n, pop && empty)
  `SHCM_NEVER(a_push_full, clk, rst_n, push && full)

endmodule

FILE: rtl/core/shcm_front.sv
// front end: configuration registers, input transfer and item classification
module shcm_front #(
  parameter int MAX_ROWS = shcm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = shcm_pkg::MAX_COLS_DEF,
  parameter int CIW      = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_mode,
  input  logic [5:0]            in_row,
  input  logic [5:0]            in_col,
  input  logic signed [31:0]    in_value_re,
  input  logic signed [31:0]    in_value_im,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_wdata,
  output shcm_pkg::cfg_t        cfg,
  output logic [CIW-1:0]        nc_m1,
  input  logic                  q_full,
  output logic                  push,
  output shcm_pkg::entry_t      push_data
);

  logic signed [31:0] alpha_re_r, alpha_im_r, beta_re_r, beta_im_r;
  logic [6:0]         num_rows_r, num_cols_r;
  logic [12:0]        nr_eff, nc_eff;
  logic               elem_ok, nz_ok, keep;
  shcm_pkg::op_t      op;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_re_r <= 32'sd65536;
      alpha_im_r <= '0;
      beta_re_r  <= '0;
      beta_im_r  <= '0;
      num_rows_r <= 7'd64;
      num_cols_r <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        shcm_pkg::REG_ALPHA_RE: alpha_re_r <= cfg_wdata;
        shcm_pkg::REG_ALPHA_IM: alpha_im_r <= cfg_wdata;
        shcm_pkg::REG_BETA_RE:  beta_re_r  <= cfg_wdata;
        shcm_pkg::REG_BETA_IM:  beta_im_r  <= cfg_wdata;
        shcm_pkg::REG_NUM_ROWS: num_rows_r <= cfg_wdata[6:0];
        shcm_pkg::REG_NUM_COLS: num_cols_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign cfg.alpha.re = alpha_re_r;
  assign cfg.alpha.im = alpha_im_r;
  assign cfg.beta.re  = beta_re_r;
  assign cfg.beta.im  = beta_im_r;

  // sizes in use, clamped to the store shape
  always_comb begin
    nr_eff = (num_rows_r == 7'd0) ? 13'd1 :
             ((13'(num_rows_r) > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : 13'(num_rows_r));
    nc_eff = (num_cols_r == 7'd0) ? 13'd1 :
             ((13'(num_cols_r) > 13'(MAX_COLS)) ? 13'(MAX_COLS) : 13'(num_cols_r));
  end

  assign nc_m1 = CIW'(nc_eff - 13'd1);

  // classify the item; ignored items are consumed without a queue entry
  always_comb begin
    elem_ok = (13'(in_row) < nr_eff) && (13'(in_col) < nc_eff);
    nz_ok   = (in_col < in_row) && (13'(in_row) < nr_eff);
    op      = shcm_pkg::OP_LDX;
    keep    = 1'b0;
    case (in_mode)
      shcm_pkg::MODE_LOAD_X: begin
        op   = shcm_pkg::OP_LDX;
        keep = elem_ok;
      end
      shcm_pkg::MODE_LOAD_Y: begin
        op   = shcm_pkg::OP_LDY;
        keep = elem_ok;
      end
      shcm_pkg::MODE_NZ: begin
        op   = shcm_pkg::OP_NZ;
        keep = nz_ok;
      end
      shcm_pkg::MODE_READ: begin
        op   = elem_ok ? shcm_pkg::OP_RD : shcm_pkg::OP_RDZ;
        keep = 1'b1;
      end
      default: ;
    endcase
  end

  assign push         = in_valid && in_ready && keep;
  assign push_data.op = op;
  assign push_data.row  = in_row;
  assign push_data.col  = in_col;
  assign push_data.v.re = in_value_re;
  assign push_data.v.im = in_value_im;

endmodule

FILE: rtl/core/shcm_back.sv
// back end: sequencer, complex multiply pipeline, x and y stores, result register
`include "assert_macros.svh"
module shcm_back #(
  parameter int MAX_ROWS = shcm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = shcm_pkg::MAX_COLS_DEF,
  parameter int CIW      = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  shcm_pkg::cfg_t     cfg,
  input  logic [CIW-1:0]     nc_m1,
  input  logic               q_empty,
  input  shcm_pkg::entry_t   q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_re,
  output logic signed [31:0] out_result_im
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PRE    = 6'b000010,
    ST_GAP    = 6'b000100,
    ST_PASS_A = 6'b001000,
    ST_PASS_B = 6'b010000,
    ST_M1     = 6'b100000
  } state_t;

  function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] r, input logic [AW-1:0] c);
    return AW'(r * AW'(MAX_COLS)) + c;
  endfunction

  state_t state_r, state_nxt;
  logic [CIW-1:0] c_r, c_nxt;
  shcm_pkg::entry_t it_r;

  // store ports
  logic          x_we, y_we;
  logic [AW-1:0] x_waddr, x_raddr, y_raddr;
  shcm_pkg::cplx_t x_wdata, x_rdata, y_wdata, y_rdata;

  // issue slot
  logic            iss_valid, iss_sel, start, is_read;
  shcm_pkg::kind_t iss_kind;
  logic [AW-1:0]   iss_yaddr;

  // pipeline stages
  logic            s1_valid_r, s1_sel_r;
  shcm_pkg::kind_t s1_kind_r;
  logic [AW-1:0]   s1_yaddr_r;
  logic            s2_valid_r, s2_cj_r;
  shcm_pkg::kind_t s2_kind_r;
  logic [AW-1:0]   s2_yaddr_r;
  logic signed [63:0] s2_rr_r, s2_ii_r, s2_ri_r, s2_ir_r;
  shcm_pkg::cplx_t s2_yold_r;
  logic            s3_valid_r;
  shcm_pkg::kind_t s3_kind_r;
  logic [AW-1:0]   s3_yaddr_r;
  shcm_pkg::cplx_t s3_prod_r, s3_yold_r;

  shcm_pkg::cplx_t val_r, valc_r, tmp_r, op_a, op_b, acc_base;
  logic            op_cj;
  logic signed [47:0] rr_q, ii_q, ri_q, ir_q;
  logic signed [48:0] re_sum, im_sum;

  logic            out_valid_r;
  shcm_pkg::cplx_t out_r;

  shcm_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(x_raddr), .rdata(x_rdata)
  );

  shcm_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_y_ram (
    .clk(clk), .we(y_we), .waddr(s3_yaddr_r), .wdata(y_wdata),
    .raddr(y_raddr), .rdata(y_rdata)
  );

  // start an item only with the pipeline drained and, for reads, a free result slot
  assign is_read = (q_data.op == shcm_pkg::OP_RD) || (q_data.op == shcm_pkg::OP_RDZ);
  assign start   = (state_r == ST_IDLE) && !q_empty && !s1_valid_r && !s2_valid_r &&
                   !s3_valid_r && !(is_read && out_valid_r);
  assign q_pop   = start;

  // sequencer: issues at most one micro op per cycle
  always_comb begin
    state_nxt = state_r;
    c_nxt     = c_r;
    iss_valid = 1'b0;
    iss_kind  = shcm_pkg::K_RD;
    iss_sel   = 1'b0;
    iss_yaddr = '0;
    x_raddr   = '0;
    x_we      = 1'b0;
    x_waddr   = addr_of(AW'(q_data.row), AW'(q_data.col));
    x_wdata   = q_data.v;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (q_data.op)
            shcm_pkg::OP_LDX: x_we = 1'b1;
            shcm_pkg::OP_LDY: begin
              iss_valid = 1'b1;
              iss_kind  = shcm_pkg::K_BV;
              state_nxt = ST_M1;
            end
            shcm_pkg::OP_NZ: begin
              iss_valid = 1'b1;
              iss_kind  = shcm_pkg::K_VAL;
              state_nxt = ST_PRE;
            end
            shcm_pkg::OP_RD: begin
              iss_valid = 1'b1;
              iss_kind  = shcm_pkg::K_RD;
              iss_yaddr = addr_of(AW'(q_data.row), AW'(q_data.col));
            end
            default: ;
          endcase
        end
      end
      ST_PRE: begin
        iss_valid = 1'b1;
        iss_kind  = shcm_pkg::K_VALC;
        state_nxt = ST_GAP;
      end
      // lets alpha*v settle before the first column uses it
      ST_GAP: begin
        c_nxt     = '0;
        state_nxt = ST_PASS_A;
      end
      ST_PASS_A: begin
        iss_valid = 1'b1;
        iss_kind  = shcm_pkg::K_MAC;
        x_raddr   = addr_of(AW'(it_r.col), AW'(c_r));
        iss_yaddr = addr_of(AW'(it_r.row), AW'(c_r));
        if (c_r == nc_m1) begin
          c_nxt     = '0;
          state_nxt = ST_PASS_B;
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      ST_PASS_B: begin
        iss_valid = 1'b1;
        iss_kind  = shcm_pkg::K_MAC;
        iss_sel   = 1'b1;
        x_raddr   = addr_of(AW'(it_r.row), AW'(c_r));
        iss_yaddr = addr_of(AW'(it_r.col), AW'(c_r));
        if (c_r == nc_m1) begin
          c_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      ST_M1: begin
        iss_valid = 1'b1;
        iss_kind  = shcm_pkg::K_AX;
        x_raddr   = addr_of(AW'(it_r.row), AW'(it_r.col));
        iss_yaddr = x_raddr;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign y_raddr = iss_yaddr;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      c_r        <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      c_r        <= c_nxt;
      s1_valid_r <= iss_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // held item
  always_ff @(posedge clk) begin
    if (start) begin
      it_r <= q_data;
    end
  end

  // stage one operand select
  always_comb begin
    op_a  = '0;
    op_b  = '0;
    op_cj = 1'b0;
    case (s1_kind_r)
      shcm_pkg::K_VAL: begin
        op_a = cfg.alpha;
        op_b = it_r.v;
      end
      shcm_pkg::K_VALC: begin
        op_a  = cfg.alpha;
        op_b  = it_r.v;
        op_cj = 1'b1;
      end
      shcm_pkg::K_BV: begin
        op_a = cfg.beta;
        op_b = it_r.v;
      end
      shcm_pkg::K_AX: begin
        op_a = cfg.alpha;
        op_b = x_rdata;
      end
      shcm_pkg::K_MAC: begin
        op_a = s1_sel_r ? valc_r : val_r;
        op_b = x_rdata;
      end
      default: ;
    endcase
  end

  // stage two combine: floor shift of each product, then sum and saturate
  always_comb begin
    rr_q = s2_rr_r[63:16];
    ii_q = s2_ii_r[63:16];
    ri_q = s2_ri_r[63:16];
    ir_q = s2_ir_r[63:16];
    if (s2_cj_r) begin
      re_sum = 49'(rr_q) + 49'(ii_q);
      im_sum = 49'(ir_q) - 49'(ri_q);
    end else begin
      re_sum = 49'(rr_q) - 49'(ii_q);
      im_sum = 49'(ri_q) + 49'(ir_q);
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_kind_r  <= iss_kind;
    s1_sel_r   <= iss_sel;
    s1_yaddr_r <= iss_yaddr;
    s2_kind_r  <= s1_kind_r;
    s2_yaddr_r <= s1_yaddr_r;
    s2_cj_r    <= op_cj;
    s2_rr_r    <= op_a.re * op_b.re;
    s2_ii_r    <= op_a.im * op_b.im;
    s2_ri_r    <= op_a.re * op_b.im;
    s2_ir_r    <= op_a.im * op_b.re;
    s2_yold_r  <= y_rdata;
    s3_kind_r  <= s2_kind_r;
    s3_yaddr_r <= s2_yaddr_r;
    s3_prod_r.re <= shcm_pkg::sat32(re_sum);
    s3_prod_r.im <= shcm_pkg::sat32(im_sum);
    s3_yold_r  <= s2_yold_r;
  end

  // stage three: accumulate into y or keep the scaled value
  assign acc_base   = (s3_kind_r == shcm_pkg::K_AX) ? tmp_r : s3_yold_r;
  assign y_wdata.re = shcm_pkg::sat32(49'(acc_base.re) + 49'(s3_prod_r.re));
  assign y_wdata.im = shcm_pkg::sat32(49'(acc_base.im) + 49'(s3_prod_r.im));
  assign y_we       = s3_valid_r &&
                      ((s3_kind_r == shcm_pkg::K_MAC) || (s3_kind_r == shcm_pkg::K_AX));

  always_ff @(posedge clk) begin
    if (s3_valid_r) begin
      case (s3_kind_r)
        shcm_pkg::K_VAL:  val_r  <= s3_prod_r;
        shcm_pkg::K_VALC: valc_r <= s3_prod_r;
        shcm_pkg::K_BV:   tmp_r  <= s3_prod_r;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_valid_r && s3_kind_r == shcm_pkg::K_RD) begin
      out_valid_r <= 1'b1;
    end else if (start && q_data.op == shcm_pkg::OP_RDZ) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid_r && s3_kind_r == shcm_pkg::K_RD) begin
      out_r <= s3_yold_r;
    end else if (start && q_data.op == shcm_pkg::OP_RDZ) begin
      out_r <= '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result_re = out_r.re;
  assign out_result_im = out_r.im;

  `SHCM_ASSERT(a_rd_slot_free, clk, rst_n, (s3_valid_r && s3_kind_r == shcm_pkg::K_RD) |-> !out_valid_r)
  `SHCM_ASSERT(a_rd_delivers, clk, rst_n, (s3_valid_r && s3_kind_r == shcm_pkg::K_RD) |=> out_valid_r)
  `SHCM_ASSERT(a_pass_order, clk, rst_n, (state_r == ST_PASS_B) |-> ($past(state_r) == ST_PASS_A || $past(state_r) == ST_PASS_B))
  `SHCM_NEVER(a_store_clash, clk, rst_n, x_we && (y_we || s1_valid_r))

endmodule

FILE: rtl/core/sparse_hermitian_coo_matmul_unit.sv
// top level of the sparse hermitian coordinate-format matrix multiply unit
// Computes Y = beta*Y + alpha*A*X on complex Q16.16 data held in two on-chip stores of
// MAX_ROWS*MAX_COLS entries. Items pass through a four-entry queue, so the input side
// keeps taking items, until the queue is full, while the back end works or a read result
// waits. A nonzero below the diagonal makes one pass over the columns to update its row
// of Y and a second for the mirrored row, one complex multiply-accumulate per cycle
// through a three-stage pipeline of four 32x32 multipliers, bounded by the single read
// port of each store. Items that change Y do not overlap, so each starts once the
// pipeline has drained. Unwritten store entries read back undefined.
module sparse_hermitian_coo_matmul_unit #(
  parameter int MAX_ROWS = shcm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = shcm_pkg::MAX_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [5:0]         in_row,
  input  logic [5:0]         in_col,
  input  logic signed [31:0] in_value_re,
  input  logic signed [31:0] in_value_im,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_re,
  output logic signed [31:0] out_result_im,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int EW  = $bits(shcm_pkg::entry_t);

  shcm_pkg::cfg_t   cfg;
  shcm_pkg::entry_t push_data, q_data;
  logic [EW-1:0]    q_rdata;
  logic [CIW-1:0]   nc_m1;
  logic             push, q_pop, q_full, q_empty;

  shcm_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .CIW(CIW)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_row(in_row), .in_col(in_col),
    .in_value_re(in_value_re), .in_value_im(in_value_im),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .cfg(cfg), .nc_m1(nc_m1),
    .q_full(q_full), .push(push), .push_data(push_data)
  );

  shcm_queue #(.WIDTH(EW), .DEPTH(shcm_pkg::QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wdata(push_data),
    .pop(q_pop), .rdata(q_rdata),
    .full(q_full), .empty(q_empty)
  );

  assign q_data = shcm_pkg::entry_t'(q_rdata);

  shcm_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .CIW(CIW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .cfg(cfg), .nc_m1(nc_m1),
    .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_re(out_result_re), .out_result_im(out_result_im)
  );

endmodule
